[design/aabbscr_pkg.sv]
// Types, codes and helpers shared by the swept box collision resolver.
// Depends on nothing; every design file imports it.
package aabbscr_pkg;

  localparam int COORD_W = 24;
  localparam int SIZE_W  = 16;
  localparam int LIMIT_W = 23;
  localparam int KIND_W  = 2;
  localparam int IN_W    = 128;
  localparam int OUT_W   = 56;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   span_t;

  typedef struct packed {
    coord_t            x;
    coord_t            y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } barrier_t;

  typedef struct packed {
    span_t             left;
    span_t             right;
    span_t             top;
    span_t             bot;
    span_t             old_left;
    span_t             old_right;
    span_t             old_top;
    span_t             old_bot;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic              hpos;
    logic              hneg;
    logic              vpos;
    logic              vneg;
  } actor_t;

  typedef struct packed {
    span_t rx;
    span_t ry;
    logic  th;
    logic  tv;
  } sweep_res_t;

  function automatic span_t ext(coord_t v);
    return {v[COORD_W-1], v};
  endfunction

  function automatic span_t add_size(coord_t v, logic [SIZE_W-1:0] s);
    return {v[COORD_W-1], v} + {{(COORD_W+1-SIZE_W){1'b0}}, s};
  endfunction

  function automatic span_t sub_size(span_t v, logic [SIZE_W-1:0] s);
    return v - {{(COORD_W+1-SIZE_W){1'b0}}, s};
  endfunction

  function automatic coord_t sat24(span_t v);
    coord_t r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/aabbscr_table.sv]
// Barrier table: one write port, one read port with registered read data.
// Depends on aabbscr_pkg for the barrier entry type.
module aabbscr_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  aabbscr_pkg::barrier_t wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output aabbscr_pkg::barrier_t rdata
);
  import aabbscr_pkg::*;

  barrier_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/aabbscr_test.sv]
// Per-barrier sweep test: edge stage, then compare and clamp into accumulators.
// Depends on aabbscr_pkg for the actor, barrier and result types.
module aabbscr_test (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  aabbscr_pkg::actor_t     actor_in,
  input  logic                    in_valid,
  input  aabbscr_pkg::barrier_t   barrier,
  output logic                    busy,
  output aabbscr_pkg::sweep_res_t res
);
  import aabbscr_pkg::*;

  actor_t actor;
  logic   e_valid;
  span_t  bl, br, bt, bb, bt_mh, bl_mw;
  logic   xmeet, ymeet;
  logic   hit_up, hit_down, hit_right, hit_left;
  sweep_res_t res_next;

  always_ff @(posedge clk) begin
    if (start) begin
      actor <= actor_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      bl    <= ext(barrier.x);
      br    <= add_size(barrier.x, barrier.w);
      bt    <= ext(barrier.y);
      bb    <= add_size(barrier.y, barrier.h);
      bt_mh <= sub_size(ext(barrier.y), actor.h);
      bl_mw <= sub_size(ext(barrier.x), actor.w);
    end
  end

  assign busy = e_valid;

  always_comb begin
    xmeet = (actor.left >= bl && actor.left < br) ||
            (actor.right <= br && actor.right > bl) ||
            (actor.left < bl && actor.right > br);
    ymeet = (actor.top >= bt && actor.top < bb) ||
            (actor.bot <= bb && actor.bot > bt) ||
            (actor.top < bt && actor.bot > bb);
    hit_up    = actor.vneg && bb > actor.top && bb <= actor.old_top && xmeet;
    hit_down  = actor.vpos && bt < actor.bot && bt >= actor.old_bot && xmeet;
    hit_right = actor.hpos && bl < actor.right && bl >= actor.old_right && ymeet;
    hit_left  = actor.hneg && br > actor.left && br <= actor.old_left && ymeet;
    res_next = res;
    if (hit_up || hit_down) begin
      res_next.tv = 1'b1;
    end
    if (hit_up && res.ry < bb) begin
      res_next.ry = bb;
    end
    if (hit_down && res.ry > bt_mh) begin
      res_next.ry = bt_mh;
    end
    if (hit_right || hit_left) begin
      res_next.th = 1'b1;
    end
    if (hit_right && res.rx > bl_mw) begin
      res_next.rx = bl_mw;
    end
    if (hit_left && res.rx < br) begin
      res_next.rx = br;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      res.rx <= actor_in.left;
      res.ry <= actor_in.top;
      res.th <= 1'b0;
      res.tv <= 1'b0;
    end else if (e_valid) begin
      res <= res_next;
    end
  end

endmodule

[design/aabb_sweep_collision_resolver.sv]
// Top level: request sequencer, barrier count, fall limit and result register.
// Depends on aabbscr_pkg, aabbscr_table and aabbscr_test.
//
//   channel | direction | handshake        | payload
//   s       | in        | s_tvalid/tready  | s_tdata (positions, sizes), s_tuser (kind)
//   m       | out       | m_tvalid/tready  | m_tdata (resolved corner, flags), m_tuser
//   cfg     | in        | cfg_we           | cfg_wdata (fall limit)
//
// A move request over a non-empty table scans it after accept: the table has
// one read port, so the scan reads one barrier per cycle, then the drain state
// waits out the read and edge pipeline and the result state loads the result
// register. Any other request, or a move over an empty table, skips the scan.
// Reset empties the table and sets the fall limit to its maximum.
// One request is in work at a time; accept opens once the result register is
// loaded, and a result still waiting holds the next one in its last stage.
module aabb_sweep_collision_resolver #(
  parameter int MAX_BARRIERS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // pos_x, pos_y, old_x, old_y, size_w, size_h
  input  logic [aabbscr_pkg::IN_W-1:0]           s_tdata,
  // kind
  input  logic [aabbscr_pkg::KIND_W-1:0]         s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // resolved_x, resolved_y, touched_horizontal, touched_vertical, fell, zero pad
  output logic [aabbscr_pkg::OUT_W-1:0]          m_tdata,
  // status
  output logic                                   m_tuser,
  input  logic                                   cfg_we,
  input  logic [aabbscr_pkg::LIMIT_W-1:0]        cfg_wdata
);
  import aabbscr_pkg::*;

  localparam int AW = (MAX_BARRIERS > 1) ? $clog2(MAX_BARRIERS) : 1;
  localparam int CW = $clog2(MAX_BARRIERS + 1);

  state_t            state, state_next;
  logic [CW-1:0]     barrier_count;
  logic [AW-1:0]     scan_addr;
  logic [LIMIT_W-1:0] fall_limit;
  logic              rd_valid;
  logic              is_move, fell_flag, status_flag;
  logic              accept, rd_en, load_out, scan_last, table_full;
  kind_t             kind;
  coord_t            in_px, in_py, in_ox, in_oy;
  logic [SIZE_W-1:0] in_w, in_h;
  actor_t            actor_in;
  barrier_t          wr_entry, rd_entry;
  logic              test_busy;
  sweep_res_t        sweep;
  coord_t            out_x, out_y;

  assign kind  = kind_t'(s_tuser);
  assign in_px = s_tdata[23:0];
  assign in_py = s_tdata[47:24];
  assign in_ox = s_tdata[71:48];
  assign in_oy = s_tdata[95:72];
  assign in_w  = s_tdata[111:96];
  assign in_h  = s_tdata[127:112];

  assign accept     = s_tvalid && s_tready;
  assign table_full = barrier_count >= CW'(MAX_BARRIERS);
  assign scan_last  = (CW'(scan_addr) + CW'(1)) == barrier_count;

  always_comb begin
    actor_in.left      = ext(in_px);
    actor_in.right     = add_size(in_px, in_w);
    actor_in.top       = ext(in_py);
    actor_in.bot       = add_size(in_py, in_h);
    actor_in.old_left  = ext(in_ox);
    actor_in.old_right = add_size(in_ox, in_w);
    actor_in.old_top   = ext(in_oy);
    actor_in.old_bot   = add_size(in_oy, in_h);
    actor_in.w         = in_w;
    actor_in.h         = in_h;
    actor_in.hpos      = in_ox < in_px;
    actor_in.hneg      = in_ox > in_px;
    actor_in.vpos      = in_oy < in_py;
    actor_in.vneg      = in_oy > in_py;
  end

  assign wr_entry = '{x: in_px, y: in_py, w: in_w, h: in_h};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (kind == KIND_MOVE && barrier_count != '0) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !test_busy) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_SCAN:   rd_en = 1'b1;
      ST_DRAIN:  ;
      ST_RESULT: load_out = !m_tvalid || m_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      barrier_count <= '0;
      scan_addr     <= '0;
      fall_limit    <= {LIMIT_W{1'b1}};
      rd_valid      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (cfg_we) begin
        fall_limit <= cfg_wdata;
      end
      if (accept && kind == KIND_ADD && !table_full) begin
        barrier_count <= barrier_count + CW'(1);
      end else if (accept && kind == KIND_CLEAR) begin
        barrier_count <= '0;
      end
      if (accept) begin
        scan_addr <= '0;
      end else if (rd_en) begin
        scan_addr <= scan_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_move     <= kind == KIND_MOVE;
      status_flag <= kind == KIND_ADD && table_full;
      fell_flag   <= actor_in.bot >= span_t'({2'b00, fall_limit});
    end
  end

  aabbscr_table #(
    .DEPTH (MAX_BARRIERS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (accept && kind == KIND_ADD && !table_full),
    .waddr (barrier_count[AW-1:0]),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (scan_addr),
    .rdata (rd_entry)
  );

  aabbscr_test u_test (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && kind == KIND_MOVE),
    .actor_in (actor_in),
    .in_valid (rd_valid),
    .barrier  (rd_entry),
    .busy     (test_busy),
    .res      (sweep)
  );

  assign out_x = sat24(sweep.rx);
  assign out_y = sat24(sweep.ry);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= status_flag;
      if (is_move) begin
        m_tdata <= {5'b0, fell_flag, sweep.tv, sweep.th, out_y, out_x};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    barrier_count <= CW'(MAX_BARRIERS))
    else $error("barrier count beyond table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_CLEAR |=> barrier_count == '0)
    else $error("clear request left barriers in table");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CW'(scan_addr) < barrier_count)
    else $error("scan address past stored barriers");

  a_result_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_RESULT |-> !rd_valid && !test_busy)
    else $error("result taken while sweep pipeline busy");

endmodule
